// File: rtl/crr_pkg.sv
// ----------------------------------------------------------------------------
// crr_pkg
// Types and constants shared by the region resizer modules.
// ----------------------------------------------------------------------------
package crr_pkg;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_READ,
		S_CALC,
		S_WALK,
		S_RESULT
	} state_t;

	localparam logic [1:0] STATUS_DONE    = 2'd0;
	localparam logic [1:0] STATUS_NO_ROOM = 2'd1;
	localparam logic [1:0] STATUS_TOO_BIG = 2'd2;

	localparam logic [15:0] MAX_REGION_RESET = 16'd31744;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic init;   // write one reset entry of the tables
		logic cap;    // capture a request and read its table entries
		logic calc1;  // round the old and new sizes
		logic calc2;  // decide status, update length and free count
		logic walk;   // read one later offset entry for shifting
		logic load;   // move the finished result into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic init_last;
		logic need_walk;
		logic walk_last;
	} sts_t;

	// Size rounded up to 16 bytes, never less than 16.
	function automatic logic [16:0] round16(input logic [15:0] n);
		logic [16:0] s;
		s = {1'b0, n} + 17'd15;
		if (n == 16'd0) begin
			return 17'd16;
		end
		return {s[16:4], 4'b0000};
	endfunction

endpackage

// File: rtl/crr_in_if.sv
// ----------------------------------------------------------------------------
// crr_in_if
// Request channel of the region resizer.
// ----------------------------------------------------------------------------
interface crr_in_if;
	logic        valid;
	logic        ready;
	logic        region_kind;
	logic [6:0]  slot_id;
	logic [15:0] new_length;

	modport source(output valid, region_kind, slot_id, new_length, input ready);
	modport sink(input valid, region_kind, slot_id, new_length, output ready);
endinterface

// File: rtl/crr_out_if.sv
// ----------------------------------------------------------------------------
// crr_out_if
// Result channel of the region resizer.
// ----------------------------------------------------------------------------
interface crr_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        side_page;
	logic [15:0] region_offset;
	logic        move_needed;
	logic [15:0] move_source;
	logic [15:0] move_dest;
	logic [16:0] move_length;
	logic [16:0] free_bytes;

	modport source(output valid, status, side_page, region_offset, move_needed,
		move_source, move_dest, move_length, free_bytes, input ready);
	modport sink(input valid, status, side_page, region_offset, move_needed,
		move_source, move_dest, move_length, free_bytes, output ready);
endinterface

// File: rtl/crr_ctrl.sv
// ----------------------------------------------------------------------------
// crr_ctrl
// Sequencer of the region resizer: table clearing pass, request evaluation,
// offset walk and result hand-off.
// ----------------------------------------------------------------------------
module crr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          out_ready,
	output logic          out_valid,
	input  crr_pkg::sts_t sts,
	output crr_pkg::cmd_t cmd
);

	crr_pkg::state_t state_q, state_d;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= crr_pkg::S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			crr_pkg::S_INIT: begin
				cmd.init = 1'b1;
				if (sts.init_last) begin
					state_d = crr_pkg::S_IDLE;
				end
			end
			crr_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = crr_pkg::S_READ;
				end
			end
			crr_pkg::S_READ: begin
				cmd.calc1 = 1'b1;
				state_d   = crr_pkg::S_CALC;
			end
			crr_pkg::S_CALC: begin
				cmd.calc2 = 1'b1;
				state_d   = sts.need_walk ? crr_pkg::S_WALK : crr_pkg::S_RESULT;
			end
			crr_pkg::S_WALK: begin
				cmd.walk = 1'b1;
				if (sts.walk_last) begin
					state_d = crr_pkg::S_RESULT;
				end
			end
			crr_pkg::S_RESULT: begin
				// The previous result must have left the output register.
				if (!out_valid_q || out_ready) begin
					cmd.load = 1'b1;
					state_d  = crr_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = crr_pkg::S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/crr_dp.sv
// ----------------------------------------------------------------------------
// crr_dp
// Datapath of the region resizer: length and offset tables, size checks,
// free count, offset shift walk and result registers.
// ----------------------------------------------------------------------------
module crr_dp #(
	parameter int TEXT_SLOTS = 64,
	parameter int PROG_SLOTS = 64,
	parameter int PAGE_BYTES = 65536
) (
	input  logic          clk,
	input  logic          arst_n,
	input  crr_pkg::cmd_t cmd,
	output crr_pkg::sts_t sts,
	input  logic          region_kind,
	input  logic [6:0]    slot_id,
	input  logic [15:0]   new_length,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata,
	output logic [1:0]    status,
	output logic          side_page,
	output logic [15:0]   region_offset,
	output logic          move_needed,
	output logic [15:0]   move_source,
	output logic [15:0]   move_dest,
	output logic [16:0]   move_length,
	output logic [16:0]   free_bytes
);

	// Table order: main-page text slots, main-page program slots, then the
	// side page (text 0, program 0, global). Later regions are a contiguous
	// run of indexes in this order.
	localparam int N        = TEXT_SLOTS + PROG_SLOTS + 1;
	localparam int AW       = $clog2(N);
	localparam int CW       = $clog2(N + 1);
	localparam int MainLast = N - 4;
	localparam int FreeInit = PAGE_BYTES - 16 * (TEXT_SLOTS + PROG_SLOTS - 2);

	localparam logic [9:0]  IdxText0 = 10'(N - 3);
	localparam logic [9:0]  IdxProg0 = 10'(N - 2);
	localparam logic [9:0]  IdxGlob  = 10'(N - 1);
	localparam logic [9:0]  ProgBase = 10'(TEXT_SLOTS - 2);
	localparam logic [9:0]  TextLim  = 10'(TEXT_SLOTS);
	localparam logic [9:0]  ProgLim  = 10'(PROG_SLOTS);
	localparam logic [17:0] PageL    = 18'(PAGE_BYTES);

	logic [15:0] len_mem [N];
	logic [15:0] off_mem [N];

	logic [15:0] rd_len_q, rd_off_q;
	logic [AW-1:0] rd_addr;

	logic [CW-1:0] ptr_q, end_q;
	logic          wr_pend_q;
	logic [AW-1:0] wr_addr_q;
	logic [15:0]   dif_q;
	logic [16:0]   free_q;
	logic [15:0]   max_q;

	logic [15:0]   req_q, loc_q;
	logic [AW-1:0] idx_q;
	logic          oor_q, side_q;
	logic [16:0]   oldr_q, newr_q;

	logic [1:0]  res_status_q;
	logic        res_side_q, res_move_q;
	logic [15:0] res_offset_q, res_src_q, res_dst_q;
	logic [16:0] res_mlen_q, res_free_q;

	logic [1:0]  out_status_q;
	logic        out_side_q, out_move_q;
	logic [15:0] out_offset_q, out_src_q, out_dst_q;
	logic [16:0] out_mlen_q, out_free_q;

	// Request decode.
	logic [9:0] id10, map10;
	logic       oor_c, side_c;

	always_comb begin
		id10 = {3'b000, slot_id};
		if (region_kind) begin
			if (id10 == 10'd0) begin
				map10 = IdxProg0;
			end else if (id10 == ProgLim) begin
				map10 = IdxGlob;
			end else begin
				map10 = ProgBase + id10;
			end
			oor_c  = id10 > ProgLim;
			side_c = (id10 == 10'd0) || (id10 == ProgLim);
		end else begin
			map10  = (id10 == 10'd0) ? IdxText0 : id10 - 10'd1;
			oor_c  = id10 >= TextLim;
			side_c = id10 == 10'd0;
		end
	end

	// Reset contents for the clearing pass.
	logic [AW-1:0] init_addr;
	logic [15:0]   init_off, init_len;

	always_comb begin
		init_addr = ptr_q[AW-1:0];
		if (10'(init_addr) == IdxText0) begin
			init_off = 16'd0;
		end else if (10'(init_addr) == IdxProg0) begin
			init_off = 16'd16;
		end else if (10'(init_addr) == IdxGlob) begin
			init_off = 16'd32;
		end else begin
			init_off = 16'({init_addr, 4'b0000});
		end
		if (10'(init_addr) < 10'(TEXT_SLOTS - 1) || 10'(init_addr) == IdxText0) begin
			init_len = 16'd3;
		end else begin
			init_len = 16'd2;
		end
	end

	// Evaluation of a resize.
	logic        grow, changed, ok;
	logic [1:0]  st_c;
	logic [16:0] growth, larger, free_next;
	logic [17:0] sum18;
	logic [16:0] mlen_c;
	logic [CW-1:0] start_c, end_c;

	always_comb begin
		growth  = newr_q - oldr_q;
		grow    = newr_q > oldr_q;
		changed = newr_q != oldr_q;
		if (grow && !side_q && growth > free_q) begin
			st_c = crr_pkg::STATUS_NO_ROOM;
		end else if (grow && newr_q > {1'b0, max_q}) begin
			st_c = crr_pkg::STATUS_TOO_BIG;
		end else begin
			st_c = crr_pkg::STATUS_DONE;
		end
		ok        = !oor_q && st_c == crr_pkg::STATUS_DONE;
		free_next = (ok && changed && !side_q) ? free_q - growth : free_q;
		larger    = grow ? newr_q : oldr_q;
		sum18     = {2'b00, loc_q} + {1'b0, larger};
		mlen_c    = (sum18 >= PageL) ? 17'd0 : 17'(PageL - sum18);
		start_c   = CW'(idx_q) + CW'(1);
		end_c     = side_q ? CW'(N - 1) : CW'(MainLast);
	end

	assign sts.init_last = ptr_q == CW'(N - 1);
	assign sts.need_walk = ok && changed && (start_c <= end_c);
	assign sts.walk_last = ptr_q == end_q;

	assign rd_addr = cmd.cap ? map10[AW-1:0] : ptr_q[AW-1:0];

	// Tables. Reads are registered; a shifted entry is written back in the cycle
	// after it was read, while the walk reads the next one.
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			len_mem[init_addr] <= init_len;
		end else if (cmd.calc2 && ok) begin
			len_mem[idx_q] <= req_q;
		end
		rd_len_q <= len_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			off_mem[init_addr] <= init_off;
		end else if (wr_pend_q) begin
			off_mem[wr_addr_q] <= rd_off_q + dif_q;
		end
		rd_off_q <= off_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			end_q     <= '0;
			wr_pend_q <= 1'b0;
			free_q    <= 17'(FreeInit);
			max_q     <= crr_pkg::MAX_REGION_RESET;
		end else begin
			wr_pend_q <= cmd.walk;
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (cmd.init || cmd.walk) begin
				ptr_q <= ptr_q + CW'(1);
			end else if (cmd.calc2) begin
				ptr_q <= start_c;
			end
			if (cmd.calc2) begin
				end_q  <= end_c;
				free_q <= free_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_q <= ptr_q[AW-1:0];
		if (cmd.cap) begin
			req_q  <= new_length;
			idx_q  <= map10[AW-1:0];
			oor_q  <= oor_c;
			side_q <= side_c;
		end
		if (cmd.calc1) begin
			oldr_q <= crr_pkg::round16(rd_len_q);
			newr_q <= crr_pkg::round16(req_q);
			loc_q  <= rd_off_q;
		end
		if (cmd.calc2) begin
			dif_q        <= growth[15:0];
			res_status_q <= oor_q ? crr_pkg::STATUS_DONE : st_c;
			res_side_q   <= !oor_q && side_q;
			res_offset_q <= oor_q ? 16'd0 : loc_q;
			res_move_q   <= ok && changed;
			res_src_q    <= (ok && changed) ? loc_q + oldr_q[15:0] : 16'd0;
			res_dst_q    <= (ok && changed) ? loc_q + newr_q[15:0] : 16'd0;
			res_mlen_q   <= (ok && changed) ? mlen_c : 17'd0;
			res_free_q   <= free_next;
		end
		if (cmd.load) begin
			out_status_q <= res_status_q;
			out_side_q   <= res_side_q;
			out_offset_q <= res_offset_q;
			out_move_q   <= res_move_q;
			out_src_q    <= res_src_q;
			out_dst_q    <= res_dst_q;
			out_mlen_q   <= res_mlen_q;
			out_free_q   <= res_free_q;
		end
	end

	assign status        = out_status_q;
	assign side_page     = out_side_q;
	assign region_offset = out_offset_q;
	assign move_needed   = out_move_q;
	assign move_source   = out_src_q;
	assign move_dest     = out_dst_q;
	assign move_length   = out_mlen_q;
	assign free_bytes    = out_free_q;

endmodule

// File: rtl/compacting_region_resizer_top.sv
// ----------------------------------------------------------------------------
// compacting_region_resizer_top
// Resizes text and program regions packed in a main page and reports the
// byte move that software must perform.
// ----------------------------------------------------------------------------
// After reset the block loads the reset layout into its length and offset
// tables and takes no request until that pass ends; configuration writes
// are taken at any time. A request is then evaluated and, if the resize is
// accepted and changes the size, the offsets of the later regions in its
// page are shifted by a walk over the offset table, one entry read and one
// written per cycle; a refused or unchanged resize skips the walk.
// Requests are handled one at a time; a finished result waits in the output
// register while the next request is accepted.
module compacting_region_resizer_top #(
	parameter int TEXT_SLOTS = 64,
	parameter int PROG_SLOTS = 64,
	parameter int PAGE_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	crr_in_if.sink      in_ch,
	crr_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	crr_pkg::cmd_t cmd;
	crr_pkg::sts_t sts;

	crr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	crr_dp #(
		.TEXT_SLOTS (TEXT_SLOTS),
		.PROG_SLOTS (PROG_SLOTS),
		.PAGE_BYTES (PAGE_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.region_kind   (in_ch.region_kind),
		.slot_id       (in_ch.slot_id),
		.new_length    (in_ch.new_length),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.status        (out_ch.status),
		.side_page     (out_ch.side_page),
		.region_offset (out_ch.region_offset),
		.move_needed   (out_ch.move_needed),
		.move_source   (out_ch.move_source),
		.move_dest     (out_ch.move_dest),
		.move_length   (out_ch.move_length),
		.free_bytes    (out_ch.free_bytes)
	);

endmodule
